### design/assert_macros.svh
// Assertion helpers used by gcve_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_PROP(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`define ASSERT_NEVER(name, clk, rst, expr) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(name, clk, rst, prop)

`define ASSERT_NEVER(name, clk, rst, expr)

`endif

`endif

### design/gcve_pkg.sv
package gcve_pkg;

  localparam int VALUE_W     = 64;
  localparam int WIDTH_W     = 7;
  localparam int INC_W       = 6;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;

  localparam logic [WIDTH_W-1:0] FIRST_WIDTH_RESET     = 7'd4;
  localparam logic [INC_W-1:0]   WIDTH_INCREMENT_RESET = 6'd0;

  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_WIDTH     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH_INCREMENT = 2'd1;

  typedef struct packed {
    logic load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic rem_zero;
    logic last;
  } status_t;

endpackage

### design/gcve_if.sv
interface gcve_in_if;
  logic                          valid;
  logic                          ready;
  logic [gcve_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface gcve_out_if;
  logic                          valid;
  logic                          ready;
  logic                          has_chunk;
  logic [gcve_pkg::VALUE_W-1:0]  chunk;
  logic [gcve_pkg::WIDTH_W-1:0]  chunk_width;
  logic                          last;

  modport source (output valid, output has_chunk, output chunk, output chunk_width,
                  output last, input ready);
  modport sink   (input valid, input has_chunk, input chunk, input chunk_width,
                  input last, output ready);
endinterface

### design/gcve_datapath.sv
module gcve_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [gcve_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gcve_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [gcve_pkg::VALUE_W-1:0]     in_value,
  input  gcve_pkg::cmd_t                   cmd,
  output gcve_pkg::status_t                status,
  output logic                             has_chunk,
  output logic [gcve_pkg::VALUE_W-1:0]     chunk,
  output logic [gcve_pkg::WIDTH_W-1:0]     chunk_width,
  output logic                             last
);

  logic [gcve_pkg::WIDTH_W-1:0] first_width;
  logic [gcve_pkg::INC_W-1:0]   width_increment;
  logic [gcve_pkg::VALUE_W-1:0] remaining;
  logic [gcve_pkg::WIDTH_W-1:0] cur_width;

  logic                         wide;
  logic [gcve_pkg::VALUE_W-1:0] low_mask;
  logic [gcve_pkg::VALUE_W-1:0] shifted;
  logic [gcve_pkg::WIDTH_W-1:0] start_width;

  always_comb begin
    wide     = cur_width[gcve_pkg::WIDTH_W-1];
    low_mask = wide ? '1 :
               ((gcve_pkg::VALUE_W'(1) << cur_width[gcve_pkg::WIDTH_W-2:0])
                - gcve_pkg::VALUE_W'(1));
    shifted  = wide ? '0 : (remaining >> cur_width[gcve_pkg::WIDTH_W-2:0]);
    status.rem_zero = (remaining == '0);
    status.last     = status.rem_zero || (shifted == '0);
    start_width = (first_width == '0) ? gcve_pkg::WIDTH_W'(1) : first_width;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_width     <= gcve_pkg::FIRST_WIDTH_RESET;
      width_increment <= gcve_pkg::WIDTH_INCREMENT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gcve_pkg::CFG_FIRST_WIDTH:     first_width     <= cfg_data;
        gcve_pkg::CFG_WIDTH_INCREMENT: width_increment <= cfg_data[gcve_pkg::INC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      cur_width <= '0;
    end else if (cmd.load) begin
      remaining <= in_value;
      cur_width <= start_width;
    end else if (cmd.emit) begin
      remaining <= shifted;
      cur_width <= cur_width + gcve_pkg::WIDTH_W'(width_increment);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      has_chunk   <= !status.rem_zero;
      chunk       <= remaining & low_mask;
      chunk_width <= status.rem_zero ? '0 : cur_width;
      last        <= status.last;
    end
  end

endmodule

### design/gcve_ctrl.sv
`include "assert_macros.svh"

module gcve_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  gcve_pkg::status_t status,
  output gcve_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   slot_free;

  always_comb begin
    in_ready   = (state == S_IDLE);
    slot_free  = !out_valid || out_ready;
    cmd.load   = in_valid && in_ready;
    cmd.emit   = (state == S_RUN) && slot_free;
    state_next = state;
    unique case (state)
      S_IDLE: if (cmd.load) state_next = S_RUN;
      S_RUN:  if (cmd.emit && status.last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `ASSERT_NEVER(a_load_and_emit, clk, rst, cmd.load && cmd.emit)
  `ASSERT_PROP(a_emit_slot_free, clk, rst, cmd.emit |-> (!out_valid || out_ready))
  `ASSERT_PROP(a_last_ends_run, clk, rst, (cmd.emit && status.last) |=> (state == S_IDLE))
  `ASSERT_PROP(a_emit_sets_valid, clk, rst, cmd.emit |=> out_valid)

endmodule

### design/growing_chunk_varint_encoder_unit.sv
// Channel   Role    Payload
// in_ch     sink    value[63:0]
// out_ch    source  has_chunk, chunk[63:0], chunk_width[6:0], last
//
// A value is loaded first, then one group is emitted per cycle while the
// output slot is free; a zero value gives one group.
// Reset (rst, synchronous) restores first_width 4, width_increment 0, idle.
// A stalled result holds its group; the run pauses until it is taken.
// A new value is taken once the last group of the previous one is registered.
module growing_chunk_varint_encoder_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [gcve_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gcve_pkg::CFG_DATA_W-1:0]  cfg_data,
  gcve_in_if.sink                          in_ch,
  gcve_out_if.source                       out_ch
);

  gcve_pkg::cmd_t    cmd;
  gcve_pkg::status_t status;

  gcve_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  gcve_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_value    (in_ch.value),
    .cmd         (cmd),
    .status      (status),
    .has_chunk   (out_ch.has_chunk),
    .chunk       (out_ch.chunk),
    .chunk_width (out_ch.chunk_width),
    .last        (out_ch.last)
  );

endmodule

### test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                          has_chunk;
    logic [gcve_pkg::VALUE_W-1:0]  chunk;
    logic [gcve_pkg::WIDTH_W-1:0]  chunk_width;
    logic                          last;
  } group_t;

  localparam logic [gcve_pkg::CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;
  localparam logic [gcve_pkg::VALUE_W-1:0]     ALL_ONES        = '1;
  localparam logic [gcve_pkg::VALUE_W-1:0]     TOP_BIT         = 64'h8000_0000_0000_0000;

  logic                             clk;
  logic                             rst;
  logic                             cfg_we;
  logic [gcve_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [gcve_pkg::CFG_DATA_W-1:0]  cfg_data;

  gcve_in_if  in_ch ();
  gcve_out_if out_ch ();

  growing_chunk_varint_encoder_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  logic [gcve_pkg::WIDTH_W-1:0] first_width_q;
  logic [gcve_pkg::INC_W-1:0]   width_inc_q;
  group_t                       expected_groups[$];
  group_t                       want;
  int                           mismatches     = 0;
  int                           values_sent    = 0;
  int                           groups_checked = 0;
  int                           settings_used  = 0;
  int                           ready_hold     = 0;
  bit                           idle_on        = 1'b1;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void encode_groups(logic [gcve_pkg::VALUE_W-1:0] v);
    logic [gcve_pkg::VALUE_W-1:0] rest;
    logic [gcve_pkg::WIDTH_W-1:0] w;
    group_t                       g;
    rest = v;
    w    = first_width_q;
    if (w == 0) begin
      w = 7'd1;
    end
    if (rest == 0) begin
      g      = '0;
      g.last = 1'b1;
      expected_groups.push_back(g);
    end
    while (rest != 0) begin
      g.has_chunk   = 1'b1;
      g.chunk_width = w;
      if (w >= 64) begin
        g.chunk = rest;
        rest    = '0;
      end else begin
        g.chunk = rest & ((64'd1 << w) - 64'd1);
        rest    = rest >> w;
      end
      g.last = (rest == 0);
      w      = w + width_inc_q;
      expected_groups.push_back(g);
    end
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 40) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_groups.size() == 0) begin
        report_mismatch($sformatf("unexpected group chunk=%h width=%0d last=%b",
                                  out_ch.chunk, out_ch.chunk_width, out_ch.last));
      end else begin
        want = expected_groups.pop_front();
        groups_checked++;
        if (out_ch.has_chunk !== want.has_chunk) begin
          report_mismatch($sformatf("has_chunk %b, want %b", out_ch.has_chunk, want.has_chunk));
        end
        if (out_ch.chunk !== want.chunk) begin
          report_mismatch($sformatf("chunk %h, want %h", out_ch.chunk, want.chunk));
        end
        if (out_ch.chunk_width !== want.chunk_width) begin
          report_mismatch($sformatf("chunk_width %0d, want %0d",
                                    out_ch.chunk_width, want.chunk_width));
        end
        if (out_ch.last !== want.last) begin
          report_mismatch($sformatf("last %b, want %b", out_ch.last, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!idle_on) begin
      out_ch.ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold   <= ready_hold - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      ready_hold   <= $urandom_range(0, 9);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_value(logic [gcve_pkg::VALUE_W-1:0] v);
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    encode_groups(v);
    values_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // hold the sender until every pending group is back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_groups.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [gcve_pkg::WIDTH_W-1:0] fw, logic [gcve_pkg::INC_W-1:0] inc);
    cfg_we    <= 1'b1;
    cfg_index <= gcve_pkg::CFG_FIRST_WIDTH;
    cfg_data  <= fw;
    @(posedge clk);
    cfg_index <= gcve_pkg::CFG_WIDTH_INCREMENT;
    cfg_data  <= {$urandom_range(0, 1) == 1, inc};
    @(posedge clk);
    cfg_we        <= 1'b0;
    first_width_q = fw;
    width_inc_q   = inc;
    settings_used++;
  endtask

  task automatic test_reset_defaults();
    send_value('0);
    send_value(64'd1);
    send_value(ALL_ONES);
    send_value(TOP_BIT);
    send_value(64'hF);
    send_value(64'h10);
    settle();
  endtask

  task automatic test_width_extremes();
    set_config(7'd1, 6'd0);
    send_value(ALL_ONES);
    settle();
    set_config(7'd64, 6'd0);
    send_value(ALL_ONES);
    send_value(TOP_BIT);
    settle();
    set_config(7'd64, 6'd63);
    send_value(64'd1);
    settle();
    set_config(7'd1, 6'd63);
    send_value(ALL_ONES);
    settle();
    set_config(7'd63, 6'd63);
    send_value(ALL_ONES);
    send_value(TOP_BIT);
    settle();
    set_config(7'd5, 6'd3);
    send_value(64'h1234_5678_9ABC_DEF0);
    settle();
    set_config(7'd0, 6'd1);
    send_value(64'h5);
    send_value('0);
    settle();
    // a write to an unused index must leave both registers alone
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SPARE_INDEX;
    cfg_data  <= '1;
    @(posedge clk);
    cfg_we <= 1'b0;
    send_value(64'hFF);
    send_value(64'h8421_0000_0000_0001);
    settle();
  endtask

  task automatic test_random_encode();
    logic [gcve_pkg::WIDTH_W-1:0] fw;
    logic [gcve_pkg::INC_W-1:0]   inc;
    logic [gcve_pkg::VALUE_W-1:0] v;
    for (int phase = 0; phase < 13; phase++) begin
      idle_on = (phase < 11) && (phase % 4 != 2);
      case ($urandom_range(0, 5))
        0: fw = 7'd1;
        1: fw = 7'd64;
        2: fw = 7'd0;
        default: fw = 7'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 3))
        0: inc = 6'd0;
        1: inc = 6'd63;
        default: inc = 6'($urandom_range(0, 63));
      endcase
      set_config(fw, inc);
      for (int n = 0; n < 35; n++) begin
        case ($urandom_range(0, 9))
          0: v = '0;
          1: v = ALL_ONES;
          2: v = 64'd1 << $urandom_range(0, 63);
          default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        send_value(v);
        if ($urandom_range(0, 39) == 0) begin
          settle();
        end
      end
      settle();
    end
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= gcve_pkg::CFG_FIRST_WIDTH;
    cfg_data     <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;
    first_width_q = gcve_pkg::FIRST_WIDTH_RESET;
    width_inc_q   = gcve_pkg::WIDTH_INCREMENT_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_width_extremes();
    test_random_encode();
    settle();
    $display("encoded %0d values into %0d checked groups over %0d width settings",
             values_sent, groups_checked, settings_used);
    $display("covered zero values, full-width chunks, zero first width and growth past 64");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d groups still pending", expected_groups.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

### files.f
+incdir+design
design/gcve_pkg.sv
design/gcve_if.sv
design/gcve_datapath.sv
design/gcve_ctrl.sv
design/growing_chunk_varint_encoder_unit.sv
test/tb_top.sv
